// ===== rtl/core/rcp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types and constants of the RESP command parser: byte classes,
// the queue entry between front and back, and the result record.
// ----------------------------------------------------------------------------
package rcp_pkg;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [2:0] KIND_OTHER  = 3'd0;
    localparam logic [2:0] KIND_DIGIT  = 3'd1;
    localparam logic [2:0] KIND_CR     = 3'd2;
    localparam logic [2:0] KIND_LF     = 3'd3;
    localparam logic [2:0] KIND_STAR   = 3'd4;
    localparam logic [2:0] KIND_DOLLAR = 3'd5;

    localparam logic [1:0] STATUS_BUSY  = 2'd0;
    localparam logic [1:0] STATUS_DONE  = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    localparam logic [15:0] MAX_LENGTH_RESET = 16'd10000;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [31:0] consumed;
        logic [15:0] arg_length;
        logic        arg_done;
        logic [15:0] arg_index;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [1:0]  status;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/rcp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcp_front
// Input side: accepts a byte transfer when the queue has room and tags it
// with its character class.
// ----------------------------------------------------------------------------
module rcp_front (
    input  wire logic           i_s_tvalid,
    input  wire logic [7:0]     i_s_tdata,
    output logic                o_s_tready,
    input  wire logic           i_full,
    output logic                o_wr_en,
    output rcp_pkg::t_item      o_wr_item
);

    logic [2:0] kind;

    always_comb begin
        if (i_s_tdata >= rcp_pkg::CHAR_ZERO && i_s_tdata <= rcp_pkg::CHAR_NINE) begin
            kind = rcp_pkg::KIND_DIGIT;
        end else if (i_s_tdata == rcp_pkg::CHAR_CR) begin
            kind = rcp_pkg::KIND_CR;
        end else if (i_s_tdata == rcp_pkg::CHAR_LF) begin
            kind = rcp_pkg::KIND_LF;
        end else if (i_s_tdata == rcp_pkg::CHAR_STAR) begin
            kind = rcp_pkg::KIND_STAR;
        end else if (i_s_tdata == rcp_pkg::CHAR_DOLLAR) begin
            kind = rcp_pkg::KIND_DOLLAR;
        end else begin
            kind = rcp_pkg::KIND_OTHER;
        end
    end

    assign o_s_tready     = !i_full;
    assign o_wr_en        = i_s_tvalid && !i_full;
    assign o_wr_item.kind = kind;
    assign o_wr_item.data = i_s_tdata;

endmodule
`default_nettype wire

// ===== rtl/core/rcp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcp_queue
// Short queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module rcp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr_en,
    input  wire rcp_pkg::t_item i_wr_item,
    output logic                o_full,
    input  wire logic           i_rd_en,
    output rcp_pkg::t_item      o_rd_item,
    output logic                o_empty
);

    rcp_pkg::t_item r_mem [rcp_pkg::QUEUE_DEPTH];

    logic [rcp_pkg::QUEUE_AW:0] r_wr_ptr;
    logic [rcp_pkg::QUEUE_AW:0] r_rd_ptr;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[rcp_pkg::QUEUE_AW] != r_rd_ptr[rcp_pkg::QUEUE_AW]) &&
                     (r_wr_ptr[rcp_pkg::QUEUE_AW-1:0] == r_rd_ptr[rcp_pkg::QUEUE_AW-1:0]);
    assign o_rd_item = r_mem[r_rd_ptr[rcp_pkg::QUEUE_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr[rcp_pkg::QUEUE_AW-1:0]] <= i_wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rcp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcp_back
// Command state machine: takes classified bytes from the queue, tracks the
// headers, payloads and trailers, and holds each result in an output register.
// ----------------------------------------------------------------------------
module rcp_back #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [15:0]    i_max_length,
    input  wire logic           i_empty,
    input  wire rcp_pkg::t_item i_item,
    output logic                o_rd_en,
    output logic                o_valid,
    input  wire logic           i_ready,
    output rcp_pkg::t_result    o_result
);

    localparam logic [3:0] PH_START     = 4'd0;
    localparam logic [3:0] PH_COUNT_HDR = 4'd1;
    localparam logic [3:0] PH_DOLLAR    = 4'd2;
    localparam logic [3:0] PH_LEN_HDR   = 4'd3;
    localparam logic [3:0] PH_PAYLOAD   = 4'd4;
    localparam logic [3:0] PH_TRAIL_CR  = 4'd5;
    localparam logic [3:0] PH_TRAIL_LF  = 4'd6;
    localparam logic [3:0] PH_WAIT      = 4'd7;
    localparam logic [3:0] PH_ERROR     = 4'd8;

    localparam logic [16:0] ACC_CAP   = 17'h1FFFF;
    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    logic [3:0]            r_phase,       n_phase;
    logic [16:0]           r_acc,         n_acc;
    logic                  r_digit_seen,  n_digit_seen;
    logic                  r_hdr_fault,   n_hdr_fault;
    logic                  r_cr_seen,     n_cr_seen;
    logic [COUNT_BITS-1:0] r_args_left,   n_args_left;
    logic [COUNT_BITS-1:0] r_arg_cnt,     n_arg_cnt;
    logic [COUNT_BITS-1:0] r_bytes_left,  n_bytes_left;
    logic [COUNT_BITS-1:0] r_bulk_len,    n_bulk_len;
    logic                  r_trail_fault, n_trail_fault;
    logic [31:0]           r_total,       n_total;

    logic             r_out_valid;
    rcp_pkg::t_result r_out;
    rcp_pkg::t_result res;

    logic                  fire;
    logic                  err;
    logic                  is_digit;
    logic                  is_cr;
    logic                  is_lf;
    logic                  hdr_end;
    logic                  hdr_bad;
    logic [20:0]           acc_mul;
    logic [16:0]           acc_sat;
    logic [COUNT_BITS-1:0] hdr_val;
    logic [COUNT_BITS-1:0] bytes_dec;
    logic [COUNT_BITS-1:0] args_dec;

    assign fire     = !i_empty && (!r_out_valid || i_ready);
    assign o_rd_en  = fire;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assign is_digit = (i_item.kind == rcp_pkg::KIND_DIGIT);
    assign is_cr    = (i_item.kind == rcp_pkg::KIND_CR);
    assign is_lf    = (i_item.kind == rcp_pkg::KIND_LF);
    assign hdr_end  = is_lf && r_cr_seen;
    assign hdr_bad  = r_hdr_fault || !r_digit_seen || (r_acc > {1'b0, i_max_length}) ||
                      ({15'd0, r_acc} > COUNT_MAX);
    assign acc_mul  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} +
                      {17'd0, i_item.data[3:0]};
    assign acc_sat  = (acc_mul > {4'd0, ACC_CAP}) ? ACC_CAP : acc_mul[16:0];
    assign hdr_val  = COUNT_BITS'(r_acc);
    assign bytes_dec = r_bytes_left - 1'b1;
    assign args_dec  = r_args_left - 1'b1;

    always_comb begin
        n_phase       = r_phase;
        n_acc         = r_acc;
        n_digit_seen  = r_digit_seen;
        n_hdr_fault   = r_hdr_fault;
        n_cr_seen     = r_cr_seen;
        n_args_left   = r_args_left;
        n_arg_cnt     = r_arg_cnt;
        n_bytes_left  = r_bytes_left;
        n_bulk_len    = r_bulk_len;
        n_trail_fault = r_trail_fault;
        n_total       = r_total;
        err           = 1'b0;
        res           = '0;
        res.status    = rcp_pkg::STATUS_BUSY;
        res.arg_index = 16'(r_arg_cnt);

        if (r_phase != PH_ERROR && r_phase != PH_START && r_phase != PH_WAIT &&
            r_total != 32'hFFFF_FFFF) begin
            n_total = r_total + 32'd1;
        end

        if ((r_phase == PH_COUNT_HDR || r_phase == PH_LEN_HDR) && !hdr_end) begin
            if (r_cr_seen) begin
                n_hdr_fault = 1'b1;
                n_cr_seen   = 1'b0;
            end
            if (is_cr) begin
                n_cr_seen = 1'b1;
            end else if (is_digit) begin
                n_acc        = acc_sat;
                n_digit_seen = 1'b1;
            end else begin
                n_hdr_fault = 1'b1;
            end
        end

        unique case (r_phase)
            PH_START, PH_WAIT: begin
                if (i_item.kind == rcp_pkg::KIND_STAR) begin
                    n_acc        = '0;
                    n_digit_seen = 1'b0;
                    n_hdr_fault  = 1'b0;
                    n_cr_seen    = 1'b0;
                    n_total      = 32'd1;
                    n_arg_cnt    = '0;
                    n_phase      = PH_COUNT_HDR;
                end else if (r_phase == PH_START) begin
                    err = 1'b1;
                end
            end
            PH_COUNT_HDR: begin
                if (hdr_end) begin
                    n_cr_seen = 1'b0;
                    if (hdr_bad) begin
                        err = 1'b1;
                    end else begin
                        n_args_left = hdr_val;
                        n_arg_cnt   = '0;
                        if (r_acc == '0) begin
                            res.status   = rcp_pkg::STATUS_DONE;
                            res.consumed = n_total;
                            n_phase      = PH_WAIT;
                        end else begin
                            n_phase = PH_DOLLAR;
                        end
                    end
                end
            end
            PH_DOLLAR: begin
                if (i_item.kind == rcp_pkg::KIND_DOLLAR) begin
                    n_acc        = '0;
                    n_digit_seen = 1'b0;
                    n_hdr_fault  = 1'b0;
                    n_cr_seen    = 1'b0;
                    n_phase      = PH_LEN_HDR;
                end else begin
                    err = 1'b1;
                end
            end
            PH_LEN_HDR: begin
                if (hdr_end) begin
                    n_cr_seen = 1'b0;
                    if (hdr_bad) begin
                        err = 1'b1;
                    end else begin
                        n_bulk_len    = hdr_val;
                        n_bytes_left  = hdr_val;
                        n_trail_fault = 1'b0;
                        n_phase       = (r_acc == '0) ? PH_TRAIL_CR : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = i_item.data;
                n_bytes_left      = bytes_dec;
                if (bytes_dec == '0) begin
                    n_phase = PH_TRAIL_CR;
                end
            end
            PH_TRAIL_CR: begin
                n_trail_fault = !is_cr;
                n_phase       = PH_TRAIL_LF;
            end
            PH_TRAIL_LF: begin
                if (r_trail_fault || !is_lf) begin
                    err = 1'b1;
                end else begin
                    res.arg_done   = 1'b1;
                    res.arg_length = 16'(r_bulk_len);
                    n_args_left    = args_dec;
                    if (args_dec == '0) begin
                        res.status   = rcp_pkg::STATUS_DONE;
                        res.consumed = n_total;
                        n_arg_cnt    = '0;
                        n_phase      = PH_WAIT;
                    end else begin
                        n_arg_cnt = r_arg_cnt + 1'b1;
                        n_phase   = PH_DOLLAR;
                    end
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase

        if (err) begin
            n_phase       = PH_ERROR;
            res           = '0;
            res.status    = rcp_pkg::STATUS_ERROR;
            res.arg_index = 16'(r_arg_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_acc         <= '0;
            r_digit_seen  <= 1'b0;
            r_hdr_fault   <= 1'b0;
            r_cr_seen     <= 1'b0;
            r_args_left   <= '0;
            r_arg_cnt     <= '0;
            r_bytes_left  <= '0;
            r_bulk_len    <= '0;
            r_trail_fault <= 1'b0;
            r_total       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_phase       <= n_phase;
                r_acc         <= n_acc;
                r_digit_seen  <= n_digit_seen;
                r_hdr_fault   <= n_hdr_fault;
                r_cr_seen     <= n_cr_seen;
                r_args_left   <= n_args_left;
                r_arg_cnt     <= n_arg_cnt;
                r_bytes_left  <= n_bytes_left;
                r_bulk_len    <= n_bulk_len;
                r_trail_fault <= n_trail_fault;
                r_total       <= n_total;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/resp_command_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// resp_command_parser
// Parses a RESP array of bulk strings one byte per transfer and gives one
// result transfer per input byte.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one result, in order. The block takes one
// byte per cycle at full rate while the queue has room; each result passes
// through the four-entry byte queue and then the output register. The input
// keeps accepting while the queue has room, so a stalled output fills the
// queue before the input side stalls. The user must write max_length through
// i_cfg_we / i_cfg_wdata while no command is in flight; the block does not enforce it.
module resp_command_parser #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,   // [7:0] payload_byte, [23:8] arg_index,
                                          // [39:24] arg_length, [71:40] consumed
    output logic [3:0]       o_m_tuser    // [1:0] status, [2] payload_valid, [3] arg_done
);

    logic [15:0]      r_max_length;
    logic             full;
    logic             empty;
    logic             wr_en;
    logic             rd_en;
    rcp_pkg::t_item   wr_item;
    rcp_pkg::t_item   rd_item;
    rcp_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= rcp_pkg::MAX_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    rcp_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .o_s_tready (o_s_tready),
        .i_full     (full),
        .o_wr_en    (wr_en),
        .o_wr_item  (wr_item)
    );

    rcp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_item (wr_item),
        .o_full    (full),
        .i_rd_en   (rd_en),
        .o_rd_item (rd_item),
        .o_empty   (empty)
    );

    rcp_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_length (r_max_length),
        .i_empty      (empty),
        .i_item       (rd_item),
        .o_rd_en      (rd_en),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_result     (result)
    );

    assign o_m_tdata = {result.consumed, result.arg_length, result.arg_index,
                        result.payload_byte};
    assign o_m_tuser = {result.arg_done, result.payload_valid, result.status};

endmodule
`default_nettype wire
